/* rtl/efpc_pkg.sv */
// efpc_pkg: shared constants and types of the fixed-point exp unit.
// Used by efpc_schr, efpc_poly and exp_fixed_poly_correction_unit; no dependencies.
package efpc_pkg;

	// argument, result and mantissa-slice widths
	localparam int XW = 24;
	localparam int IW = 31;
	localparam int MW = 16;

	// saturation bounds of the Q7.16 argument: -87.0 and +88.0
	localparam logic signed [XW-1:0] X_MIN = -24'sd5701632;
	localparam logic signed [XW-1:0] X_MAX = 24'sd5767168;

	// Schraudolph scale and exponent bias (127 << 23)
	localparam logic [23:0] EXP_SCALE = 24'd12102203;
	localparam logic [31:0] EXP_BIAS  = 32'd1065353216;
	localparam logic [15:0] TRUNC_RND = 16'hFFFF;

	// quartic correction coefficients
	localparam logic [11:0] Q_C0 = 12'd3537;
	localparam logic [14:0] Q_C1 = 15'd13668;
	localparam logic [14:0] Q_C2 = 15'd15817;
	localparam logic signed [23:0] Q_C3 = 24'sd80470;

	// cubic correction coefficients
	localparam logic [11:0] C_C0 = 12'd1277;
	localparam logic [14:0] C_C1 = 15'd14825;
	localparam logic signed [17:0] C_C2 = 18'sd79749;
	localparam logic signed [23:0] C_C3 = 24'sd626;

	// word between the integer stage and the correction stage
	typedef struct packed {
		logic [IW-1:0] ival;
		logic          quartic;
	} efpc_word_t;

endpackage

/* rtl/efpc_schr.sv */
// efpc_schr: three-stage Schraudolph integer path (clamp, scale, truncate plus bias).
// Depends on efpc_pkg.
module efpc_schr
	import efpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [XW-1:0] in_x,
	input  logic                 in_quartic,
	output logic                 out_valid,
	input  logic                 out_ready,
	output efpc_word_t           out_word
);

	logic                 v_s1, v_s2, v_s3;
	logic                 en1, en2, en3;
	logic signed [XW-1:0] x_s1;
	logic                 mode_s1, mode_s2;
	logic signed [48:0]   prod_s2;
	efpc_word_t           word_s3;

	logic signed [XW-1:0] x_clamp;
	logic signed [48:0]   prod_d;
	logic signed [48:0]   prod_rnd;
	logic signed [48:0]   q_full;
	logic signed [31:0]   i_sum;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		x_clamp = in_x;
		if (in_x < X_MIN) begin
			x_clamp = X_MIN;
		end
		if (in_x > X_MAX) begin
			x_clamp = X_MAX;
		end
	end

	assign prod_d = 49'(x_s1) * $signed({25'd0, EXP_SCALE});

	// truncate toward zero: bias negative products up before the floor shift
	assign prod_rnd = prod_s2 + (prod_s2[48] ? $signed({33'd0, TRUNC_RND}) : 49'sd0);
	assign q_full   = prod_rnd >>> 16;
	assign i_sum    = q_full[31:0] + $signed(EXP_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= x_clamp;
			mode_s1 <= in_quartic;
		end
		if (en2) begin
			prod_s2 <= prod_d;
			mode_s2 <= mode_s1;
		end
		if (en3) begin
			word_s3.ival    <= i_sum[IW-1:0];
			word_s3.quartic <= mode_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_word  = word_s3;

endmodule

/* rtl/efpc_poly.sv */
// efpc_poly: five-stage polynomial correction on 16 mantissa bits and final add.
// Depends on efpc_pkg; a multiplier per stage but the add; all but stage 4's (quartic only) are shared.
module efpc_poly
	import efpc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  efpc_word_t    in_word,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [IW-1:0] out_exp
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [IW-1:0] i_s1, i_s2, i_s3, i_s4;
	logic [MW-1:0] m_s1, m_s2, m_s3;
	logic          mode_s1, mode_s2, mode_s3;
	logic [14:0]          t1_s1;
	logic signed [17:0]   t2_s2;
	logic signed [23:0]   t3_s3;
	logic signed [23:0]   corr_s4;
	logic [IW-1:0]        exp_s5;

	logic [MW-1:0]      m_in;
	logic [11:0]        coef_a;
	logic [27:0]        a_prod;
	logic [27:0]        a_shift;
	logic [14:0]        t1_d;
	logic [30:0]        b_prod;
	logic [14:0]        b_quart;
	logic signed [17:0] t2_d;
	logic signed [34:0] c_prod;
	logic signed [34:0] c_sh14;
	logic signed [34:0] c_sh11;
	logic signed [23:0] t3_d;
	logic signed [40:0] d_prod;
	logic signed [40:0] d_sh11;
	logic signed [23:0] corr_d;
	logic signed [31:0] exp_sum;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// stage 1: leading coefficient times m
	assign m_in    = in_word.ival[22:7];
	assign coef_a  = in_word.quartic ? Q_C0 : C_C0;
	assign a_prod  = {16'd0, coef_a} * {12'd0, m_in};
	assign a_shift = in_word.quartic ? (a_prod >> 16) : (a_prod >> 14);
	assign t1_d    = a_shift[14:0] + (in_word.quartic ? Q_C1 : C_C1);

	// stage 2
	assign b_prod  = {16'd0, t1_s1} * {15'd0, m_s1};
	assign b_quart = b_prod[30:18] + Q_C2;
	assign t2_d    = mode_s1 ? $signed({3'd0, b_quart})
	                         : $signed({1'b0, b_prod[30:14]}) - C_C2;

	// stage 3
	assign c_prod = 35'(t2_s2) * $signed({19'd0, m_s2});
	assign c_sh14 = c_prod >>> 14;
	assign c_sh11 = c_prod >>> 11;
	assign t3_d   = mode_s2 ? (c_sh14[23:0] - Q_C3) : (c_sh11[23:0] - C_C3);

	// stage 4: quartic needs one more product; cubic is already done
	assign d_prod = 41'(t3_s3) * $signed({25'd0, m_s3});
	assign d_sh11 = d_prod >>> 11;
	assign corr_d = mode_s3 ? d_sh11[23:0] : t3_s3;

	// stage 5: add correction to the integer
	assign exp_sum = $signed({1'b0, i_s4}) + 32'(corr_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t1_s1   <= t1_d;
			i_s1    <= in_word.ival;
			m_s1    <= m_in;
			mode_s1 <= in_word.quartic;
		end
		if (en2) begin
			t2_s2   <= t2_d;
			i_s2    <= i_s1;
			m_s2    <= m_s1;
			mode_s2 <= mode_s1;
		end
		if (en3) begin
			t3_s3   <= t3_d;
			i_s3    <= i_s2;
			m_s3    <= m_s2;
			mode_s3 <= mode_s2;
		end
		if (en4) begin
			corr_s4 <= corr_d;
			i_s4    <= i_s3;
		end
		if (en5) begin
			exp_s5 <= exp_sum[IW-1:0];
		end
	end

	assign out_valid = v_s5;
	assign out_exp   = exp_s5;

endmodule

/* rtl/exp_fixed_poly_correction_unit.sv */
// exp_fixed_poly_correction_unit: top level of the fixed-point e^x unit.
// Depends on efpc_pkg, efpc_schr and efpc_poly.
//
// Usage:
//   Drive a signed Q7.16 argument on s_axis_tdata; each accepted word yields
//   one word on m_axis_tdata holding the single-precision bit pattern of an
//   approximation of e^x (sign bit always zero, carried as a zero pad bit).
//   Arguments below -87.0 or above 88.0 saturate to those bounds.
//   The approximation is the Schraudolph integer trunc(x * 12102203 / 2^16)
//   plus 127 << 23, refined by an integer polynomial in 16 mantissa bits.
//   cfg_wr_en / cfg_wr_data write quartic_mode (1 = quartic, 0 = cubic
//   correction); write it only while no word is in flight. Reset selects
//   quartic. The mode is sampled with each word and travels with it.
// Timing:
//   Eight register stages: 3 form the integer (clamp, 24x25 product,
//   truncate plus bias) and 5 apply the correction, one multiplier per
//   stage, then the final add. m_axis_tvalid is the registered valid bit
//   of that final add stage. Throughput is one word per cycle while
//   m_axis_tready stays high. Each stage holds its word while the
//   stage behind it is full and stalled, so a stalled receiver fills the
//   pipeline's bubbles first and only then drops s_axis_tready.
//   Reset clears every valid bit and empties the pipeline at once.
module exp_fixed_poly_correction_unit
	import efpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,    // quartic_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] x_fixed
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [30:0] exp_bits, [31] zero pad
);

	logic          quartic_mode_q;
	logic          mid_valid;
	logic          mid_ready;
	efpc_word_t    mid_word;
	logic [IW-1:0] exp_bits;

	// hold the mode register; to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quartic_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			quartic_mode_q <= cfg_wr_data;
		end
	end

	efpc_schr u_schr (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_x       ($signed(s_axis_tdata)),
		.in_quartic (quartic_mode_q),
		.out_valid  (mid_valid),
		.out_ready  (mid_ready),
		.out_word   (mid_word)
	);

	efpc_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_word   (mid_word),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_exp   (exp_bits)
	);

	assign m_axis_tdata = {1'b0, exp_bits};

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for exp_fixed_poly_correction_unit.
// Depends on efpc_pkg and the unit under test. Checks every result word against
// an independent bit-exact model of the exp approximation in both correction modes.
`timescale 1ns / 1ps

module testbench;
	import efpc_pkg::*;

	// correction polynomial selected by the mode register
	typedef enum bit {
		MODE_CUBIC   = 1'b0,
		MODE_QUARTIC = 1'b1
	} corr_mode_e;

	// Expected exp bit patterns, one per accepted argument, in arrival order.
	class exp_result_check;
		logic [IW-1:0] exp_bits_due[$];
		corr_mode_e    mode = MODE_QUARTIC;
		int            errors = 0;

		task report_mismatch(input string msg);
			$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		// Schraudolph integer plus polynomial correction; every shift floors but the product's, which rounds toward zero.
		function logic [IW-1:0] predict_exp_bits(input logic [XW-1:0] raw);
			longint x, prod, q, i, m, t;
			x = longint'($signed(raw));
			if (x < longint'(X_MIN))
				x = longint'(X_MIN);
			if (x > longint'(X_MAX))
				x = longint'(X_MAX);
			prod = x * 64'sd12102203;
			// drop the fraction bits, rounding toward zero
			if (prod < 0)
				q = -((-prod) >>> 16);
			else
				q = prod >>> 16;
			i = q + 64'sd1065353216;
			m = (i >>> 7) & 64'sd65535;
			if (mode == MODE_QUARTIC) begin
				t = ((64'sd3537 * m) >>> 16) + 64'sd13668;
				t = ((t * m) >>> 18) + 64'sd15817;
				t = ((t * m) >>> 14) - 64'sd80470;
				i = i + ((t * m) >>> 11);
			end else begin
				t = ((64'sd1277 * m) >>> 14) + 64'sd14825;
				t = ((t * m) >>> 14) - 64'sd79749;
				i = i + ((t * m) >>> 11) - 64'sd626;
			end
			return i[IW-1:0];
		endfunction

		function void note_argument(input logic [XW-1:0] raw);
			exp_bits_due.push_back(predict_exp_bits(raw));
		endfunction

		task check_word(input logic [IW-1:0] got);
			logic [IW-1:0] want;
			if (exp_bits_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", got));
			end else begin
				want = exp_bits_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf("exp_bits got %h want %h", got, want));
			end
		endtask

		function int pending();
			return exp_bits_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [23:0] x_fixed
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [30:0] exp_bits, [31] zero pad

	exp_result_check board = new();

	// idle percentages of the two sides, changed between phases
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;

	exp_fixed_poly_correction_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: decide the stall for the coming edge on each falling edge.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
	end

	// Sample result words at the rising edge, where the handshake happens.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata[IW-1:0]);
	end

	// Present one argument, idling at random first, and hold it until taken.
	task send_word(input logic [XW-1:0] x);
		@(negedge clk);
		while ($urandom_range(99, 0) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_argument(x);
	endtask

	// Drop valid and wait until every expected word has come back.
	task drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Write the mode register; only called with the pipeline empty.
	task write_mode(input corr_mode_e md);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= md;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		board.mode = md;
	endtask

	// Mostly legal arguments, a band near zero, and raw 24-bit words that
	// hit the saturation on both sides and toggle every bit.
	function automatic logic [XW-1:0] rand_argument();
		int sel;
		int v;
		sel = $urandom_range(99, 0);
		if (sel < 65)
			v = int'($urandom_range(11468800, 0)) - 5701632;
		else if (sel < 85)
			v = int'($urandom_range(1048576, 0)) - 524288;
		else
			v = int'($urandom());
		return v[XW-1:0];
	endfunction

	// Edges of the argument range, saturation, signs, and truncation of
	// negative products with a nonzero remainder.
	logic [XW-1:0] edge_args[] = '{
		X_MIN, X_MAX, X_MIN - 24'sd1, X_MAX + 24'sd1,
		24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF,
		24'h010000, 24'hFF0000, 24'h008000, 24'hFF8000, 24'hFFFFFD,
		24'h003039, 24'hED2979, 24'h0F4240, 24'h5A5A5A, 24'hA5A5A5
	};

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed arguments under the reset mode, then under cubic
		foreach (edge_args[k])
			send_word(edge_args[k]);
		drain();
		write_mode(MODE_CUBIC);
		foreach (edge_args[k])
			send_word(edge_args[k]);
		drain();

		// random arguments: slow receiver, then slow sender, then full rate
		for (int p = 0; p < 3; p++) begin
			snd_idle_pct = (p == 0) ? 23 : (p == 1) ? 57 : 0;
			rcv_idle_pct = (p == 0) ? 57 : (p == 1) ? 23 : 0;
			for (int md = 0; md < 2; md++) begin
				write_mode(md == 0 ? MODE_QUARTIC : MODE_CUBIC);
				repeat (125)
					send_word(rand_argument());
				drain();
			end
		end

		// let any stray word surface past the pipeline latency
		repeat (16) @(posedge clk);
		if (board.pending() != 0)
			board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
		if (board.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/efpc_pkg.sv
rtl/efpc_schr.sv
rtl/efpc_poly.sv
rtl/exp_fixed_poly_correction_unit.sv
bench/testbench.sv
